### hw/rtl/dictionary_word_match_scorer_defines.svh
// assertion helpers for the word match scorer
// every macro samples on i_clk and is disabled while i_rst_n is low
`ifndef DICTIONARY_WORD_MATCH_SCORER_DEFINES_SVH
`define DICTIONARY_WORD_MATCH_SCORER_DEFINES_SVH

// expression holds at every clock edge
`define DWMS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dwms assertion failed");

// consequent holds in the same cycle as the antecedent
`define DWMS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dwms assertion failed");

// consequent holds in the cycle after the antecedent
`define DWMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dwms assertion failed");

`endif

### hw/rtl/dwms_pkg.sv
`default_nettype none

package dwms_pkg;

    // parameter defaults
    localparam int NUM_WORDS_DEF    = 8;
    localparam int MAX_WORD_LEN_DEF = 6;
    localparam int MAX_MESSAGE_DEF  = 1024;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int MSG_LEN_W = 11;
    localparam int MATCH_W   = 11;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2c;
    localparam logic [BYTE_W-1:0] CH_HYPHEN = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_PERIOD = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3b;

    // dictionary, each word right-justified in a zero-padded field
    localparam int DICT_ROWS     = 8;
    localparam int DICT_TEXT_LEN = 8;

    typedef logic [DICT_TEXT_LEN*BYTE_W-1:0] t_dict_text;

    localparam t_dict_text DICT_TEXT [DICT_ROWS] = '{
        "bird", "campus", "class", "of", "spring", "sun", "the", "tree"
    };

    // number of characters stored for a dictionary row
    function automatic int dict_raw_len(int row);
        int n;
        n = 0;
        if (row < DICT_ROWS) begin
            for (int i = 0; i < DICT_TEXT_LEN; i++) begin
                if (DICT_TEXT[row][i*BYTE_W +: BYTE_W] != CH_NUL) begin
                    n = i + 1;
                end
            end
        end
        return n;
    endfunction

    // row length as seen by a word buffer of max_len characters
    function automatic int dict_len(int row, int max_len);
        int n;
        n = dict_raw_len(row);
        return (n < max_len) ? n : max_len;
    endfunction

    // character col of a row, counted from the start of the word
    function automatic logic [BYTE_W-1:0] dict_char(int row, int col);
        int n;
        logic [BYTE_W-1:0] c;
        n = dict_raw_len(row);
        c = CH_NUL;
        if (row < DICT_ROWS && col < n) begin
            c = DICT_TEXT[row][(n-1-col)*BYTE_W +: BYTE_W];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dwms_if.sv
`default_nettype none

// text byte channel
interface dwms_text_if;
    import dwms_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last;

    modport source (output valid, output text_byte, output last, input ready);
    modport sink   (input valid, input text_byte, input last, output ready);
endinterface

// score result channel
interface dwms_result_if;
    import dwms_pkg::*;

    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [MATCH_W-1:0] matched_chars;

    modport source (output valid, output valid_res, output matched_chars, input ready);
    modport sink   (input valid, input valid_res, input matched_chars, output ready);
endinterface

`default_nettype wire

### hw/rtl/dwms_matcher.sv
`default_nettype none

module dwms_matcher #(
    parameter int NUM_WORDS    = dwms_pkg::NUM_WORDS_DEF,
    parameter int MAX_WORD_LEN = dwms_pkg::MAX_WORD_LEN_DEF
) (
    input  logic [MAX_WORD_LEN-1:0][dwms_pkg::BYTE_W-1:0] i_chars,
    input  logic [$clog2(MAX_WORD_LEN+1)-1:0]             i_count,
    output logic                                          o_hit
);
    import dwms_pkg::*;

    localparam int CW = $clog2(MAX_WORD_LEN + 1);

    logic [NUM_WORDS-1:0] row_hit;

    // one exact compare per dictionary row, all rows in parallel
    always_comb begin
        for (int r = 0; r < NUM_WORDS; r++) begin
            row_hit[r] = (i_count == CW'(dict_len(r, MAX_WORD_LEN)));
            for (int k = 0; k < MAX_WORD_LEN; k++) begin
                if (k < dict_len(r, MAX_WORD_LEN) && i_chars[k] != dict_char(r, k)) begin
                    row_hit[r] = 1'b0;
                end
            end
        end
    end

    assign o_hit = |row_hit;

endmodule

`default_nettype wire

### hw/rtl/dictionary_word_match_scorer.sv
// Scores a byte stream against a fixed eight-word dictionary: one byte is taken
// per clock while the input is not stalled, with a registered input stage and a
// registered result stage around a single pass of word update and parallel
// dictionary compare. The result register loads when the last-marked byte
// advances out of the input register. Input stalls only when a last-marked byte
// is held behind a result that the sink has not yet taken. Words split at
// space , . ; - ( ) LF and CR; a zero byte ends the string until the last mark.
// matched_chars saturates at MAX_MESSAGE and valid_res is set when twice it
// exceeds message_length, which the user must write through i_cfg_we /
// i_cfg_wdata only while the block is idle; the block does not enforce this.
// There is no memory and no clearing pass after reset.
`default_nettype none
`include "dictionary_word_match_scorer_defines.svh"

module dictionary_word_match_scorer #(
    parameter int NUM_WORDS    = dwms_pkg::NUM_WORDS_DEF,
    parameter int MAX_WORD_LEN = dwms_pkg::MAX_WORD_LEN_DEF,
    parameter int MAX_MESSAGE  = dwms_pkg::MAX_MESSAGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dwms_pkg::MSG_LEN_W-1:0]   i_cfg_wdata,
    dwms_text_if.sink                        i_text,
    dwms_result_if.source                    o_result
);
    import dwms_pkg::*;

    localparam int CW     = $clog2(MAX_WORD_LEN + 1);
    localparam int IW     = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int TW     = $clog2(MAX_MESSAGE + 1);
    localparam int CMP_W  = (TW + 1 > MSG_LEN_W) ? TW + 1 : MSG_LEN_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WORD_LEN);
    localparam logic [TW-1:0] SAT_TOTAL = TW'(MAX_MESSAGE);
    localparam logic [TW:0]   SAT_LIMIT = (TW+1)'(MAX_MESSAGE);

    // configuration
    logic [MSG_LEN_W-1:0] r_msg_len;

    // input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // word and message state
    logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] r_chars;
    logic [CW-1:0]                       r_count;
    logic                                r_long;
    logic [TW-1:0]                       r_total;
    logic                                r_ended;

    // result stage
    logic               r_out_valid;
    logic               r_out_valid_res;
    logic [MATCH_W-1:0] r_out_matched;

    // next values and datapath
    logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] n_chars;
    logic [CW-1:0]                       n_count;
    logic                                n_long;
    logic [TW-1:0]                       n_total;
    logic                                n_ended;
    logic                                n_out_valid_res;
    logic [MATCH_W-1:0]                  n_out_matched;

    logic          advance;
    logic          is_zero;
    logic          is_delim;
    logic          live;
    logic          do_append;
    logic          set_long;
    logic          finish;
    logic          add_word;
    logic          word_hit;
    logic [CW-1:0] app_count;
    logic          app_long;
    logic [TW:0]   sum;
    logic [TW-1:0] total_new;

    // stage moves unless a final byte waits behind a stalled result
    assign advance      = r_in_valid && !(r_in_last && r_out_valid && !o_result.ready);
    assign i_text.ready = !r_in_valid || advance;

    // byte classification and word append
    always_comb begin
        is_zero   = (r_in_byte == CH_NUL);
        is_delim  = r_in_byte inside {CH_SPACE, CH_COMMA, CH_PERIOD, CH_SEMI, CH_HYPHEN,
                                      CH_LPAREN, CH_RPAREN, CH_LF, CH_CR};
        live      = !r_ended;
        do_append = live && !is_zero && !is_delim && (r_count < MAX_COUNT);
        set_long  = live && !is_zero && !is_delim && (r_count == MAX_COUNT);
        n_chars   = r_chars;
        if (do_append) begin
            n_chars[r_count[IW-1:0]] = r_in_byte;
        end
        app_count = do_append ? CW'(r_count + 1'b1) : r_count;
        app_long  = r_long | set_long;
        finish    = r_in_last || (live && (is_zero || is_delim));
    end

    dwms_matcher #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_matcher (
        .i_chars (n_chars),
        .i_count (app_count),
        .o_hit   (word_hit)
    );

    // saturating total and next state
    always_comb begin
        add_word  = finish && (app_count != '0) && !app_long && word_hit;
        sum       = {1'b0, r_total} + {{(TW+1-CW){1'b0}}, app_count};
        total_new = r_total;
        if (add_word) begin
            total_new = (sum > SAT_LIMIT) ? SAT_TOTAL : sum[TW-1:0];
        end
        if (r_in_last) begin
            n_count = '0;
            n_long  = 1'b0;
            n_total = '0;
            n_ended = 1'b0;
        end else begin
            n_count = finish ? '0 : app_count;
            n_long  = finish ? 1'b0 : app_long;
            n_total = total_new;
            n_ended = r_ended | is_zero;
        end
        n_out_valid_res = CMP_W'({total_new, 1'b0}) > CMP_W'(r_msg_len);
        n_out_matched   = MATCH_W'(total_new);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len <= '0;
        end else if (i_cfg_we) begin
            r_msg_len <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.last;
        end
    end

    // word and message state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_long  <= 1'b0;
            r_total <= '0;
            r_ended <= 1'b0;
        end else if (advance) begin
            r_count <= n_count;
            r_long  <= n_long;
            r_total <= n_total;
            r_ended <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_chars <= n_chars;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_valid_res <= n_out_valid_res;
            r_out_matched   <= n_out_matched;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.valid_res     = r_out_valid_res;
    assign o_result.matched_chars = r_out_matched;

    // checks
    `DWMS_ASSERT_ALWAYS(a_count_bound, r_count <= MAX_COUNT)
    `DWMS_ASSERT_ALWAYS(a_total_bound, r_total <= SAT_TOTAL)
    `DWMS_ASSERT_IMPLIES(a_ended_no_word, r_ended, (r_count == '0) && !r_long)
    `DWMS_ASSERT_NEXT(a_clear_after_last, advance && r_in_last, (r_count == '0) && (r_total == '0))
    `DWMS_ASSERT_NEXT(a_result_after_last, advance && r_in_last, !r_ended && r_out_valid)

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dwms_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LEX_WORDS    = 8;
    localparam int WORD_CAP     = MAX_WORD_LEN_DEF;
    localparam int SCORE_CEIL   = MAX_MESSAGE_DEF;
    localparam int N_DIRECTED   = 23;
    localparam int PHASE_ITEMS  = 78;

    typedef struct packed {
        logic               valid_res;
        logic [MATCH_W-1:0] matched_chars;
    } t_score;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last;
    } t_text_item;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last;
        logic              typed;
        t_score            want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [MSG_LEN_W-1:0] i_cfg_wdata;

    dwms_text_if   text_ch ();
    dwms_result_if score_ch ();

    dictionary_word_match_scorer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_text      (text_ch),
        .o_result    (score_ch)
    );

    // expected scores, oldest first
    t_score pending_scores [$];

    // typed expectation that travels with the byte on offer
    logic   row_typed;
    t_score row_want;

    // scorer state as predicted
    logic [MSG_LEN_W-1:0] msg_len;
    logic [47:0]          word_buf;
    int                   word_len;
    bit                   word_long;
    int                   match_total;
    bit                   text_ended;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    int mismatch_count;
    int cycle_count;

    t_text_item msg_bytes [$];
    t_dir_row   directed_rows [N_DIRECTED];

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // dictionary words, right-justified
    function automatic logic [47:0] lexicon_word(input int idx);
        case (idx)
            0: return "bird";
            1: return "campus";
            2: return "class";
            3: return "of";
            4: return "spring";
            5: return "sun";
            6: return "the";
            default: return "tree";
        endcase
    endfunction

    function automatic int lexicon_len(input int idx);
        logic [47:0] w;
        int n;
        w = lexicon_word(idx);
        n = 0;
        for (int k = 0; k < 6; k++) begin
            if (w[k*8 +: 8] != CH_NUL) begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    function automatic bit in_lexicon(input logic [47:0] w, input int n);
        for (int i = 0; i < LEX_WORDS; i++) begin
            if (n == lexicon_len(i) && w == lexicon_word(i)) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit is_delim(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || c == CH_COMMA || c == CH_PERIOD || c == CH_SEMI ||
               c == CH_HYPHEN || c == CH_LPAREN || c == CH_RPAREN || c == CH_LF ||
               c == CH_CR;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_delim();
        case ($urandom_range(8))
            0: return CH_SPACE;
            1: return CH_COMMA;
            2: return CH_PERIOD;
            3: return CH_SEMI;
            4: return CH_HYPHEN;
            5: return CH_LPAREN;
            6: return CH_RPAREN;
            7: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_letter();
        return 8'(8'h61 + $urandom_range(25));
    endfunction

    // close the current word, adding its length on a dictionary hit
    task automatic close_word();
        if (word_len != 0 && !word_long && in_lexicon(word_buf, word_len)) begin
            match_total = match_total + word_len;
            if (match_total > SCORE_CEIL) begin
                match_total = SCORE_CEIL;
            end
        end
        word_buf  = '0;
        word_len  = 0;
        word_long = 1'b0;
    endtask

    task automatic clear_message();
        word_buf    = '0;
        word_len    = 0;
        word_long   = 1'b0;
        match_total = 0;
        text_ended  = 1'b0;
    endtask

    // advance the predicted state by one text byte
    task automatic score_byte(input logic [BYTE_W-1:0] c, input logic is_last,
                              output bit has_score, output t_score score);
        has_score = 1'b0;
        score     = '0;
        if (!text_ended) begin
            if (c == CH_NUL) begin
                close_word();
                text_ended = 1'b1;
            end else if (is_delim(c)) begin
                close_word();
            end else if (word_len < WORD_CAP) begin
                word_buf = {word_buf[39:0], c};
                word_len++;
            end else begin
                word_long = 1'b1;
            end
        end
        if (is_last) begin
            if (!text_ended) begin
                close_word();
            end
            has_score           = 1'b1;
            score.valid_res     = (2 * match_total > int'(msg_len));
            score.matched_chars = MATCH_W'(match_total);
            clear_message();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch on %s: got %0d, want %0d (cycle %0d)",
                 what, got, want, cycle_count);
    endtask

    // result check, then prediction of the transaction taken at this edge
    always @(posedge i_clk) begin : score_model
        t_score predicted;
        t_score oldest;
        bit     has_score;
        if (!i_rst_n) begin
            msg_len = '0;
            clear_message();
        end else begin
            if (score_ch.valid && score_ch.ready) begin
                if (pending_scores.size() == 0) begin
                    report_mismatch("unexpected result", score_ch.matched_chars, -1);
                end else begin
                    oldest = pending_scores.pop_front();
                    if (score_ch.valid_res !== oldest.valid_res) begin
                        report_mismatch("valid_res", score_ch.valid_res, oldest.valid_res);
                    end
                    if (score_ch.matched_chars !== oldest.matched_chars) begin
                        report_mismatch("matched_chars", score_ch.matched_chars,
                                        oldest.matched_chars);
                    end
                end
            end
            if (text_ch.valid && text_ch.ready) begin
                score_byte(text_ch.text_byte, text_ch.last, has_score, predicted);
                if (has_score) begin
                    pending_scores.push_back(row_typed ? row_want : predicted);
                end
            end
            if (i_cfg_we) begin
                msg_len = i_cfg_wdata;
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dictionary_word_match_scorer regression: fail");
            $finish;
        end
    end

    // result sink: random stalls, or a long hold-off when requested
    initial begin
        score_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                score_ch.ready = 1'b0;
                hold_left--;
            end else begin
                score_ch.ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // offer one byte and wait for its transaction; returns at a falling edge
    task automatic offer_byte(input logic [BYTE_W-1:0] c, input logic is_last,
                              input logic typed, input t_score want);
        while ($urandom_range(99) < src_idle_pct) begin
            text_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        text_ch.valid     = 1'b1;
        text_ch.text_byte = c;
        text_ch.last      = is_last;
        row_typed         = typed;
        row_want          = want;
        @(posedge i_clk);
        while (!text_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic push_word(input logic [47:0] w, input int len);
        for (int j = 0; j < len; j++) begin
            msg_bytes.push_back({w[(len-1-j)*8 +: 8], 1'b0});
        end
    endtask

    // mostly well-formed text: dictionary words, near misses, junk, early ends
    task automatic build_message(input int max_words);
        int          n_words;
        int          pick;
        int          idx;
        int          len;
        int          pos;
        logic [47:0] w;
        msg_bytes.delete();
        n_words = $urandom_range(max_words, 1);
        if ($urandom_range(3) == 0) begin
            msg_bytes.push_back({pick_delim(), 1'b0});
        end
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(99);
            idx  = $urandom_range(LEX_WORDS - 1);
            w    = lexicon_word(idx);
            len  = lexicon_len(idx);
            if (pick < 55) begin
                push_word(w, len);
            end else if (pick < 70) begin
                // near miss: one letter changed, one dropped, or one added
                case ($urandom_range(2))
                    0: begin
                        pos = $urandom_range(len - 1);
                        w[(len-1-pos)*8 +: 8] = rand_letter();
                        push_word(w, len);
                    end
                    1: push_word(w >> 8, len - 1);
                    default: begin
                        push_word(w, len);
                        msg_bytes.push_back({rand_letter(), 1'b0});
                    end
                endcase
            end else if (pick < 85) begin
                len = $urandom_range(9, 1);
                for (int j = 0; j < len; j++) begin
                    msg_bytes.push_back({rand_letter(), 1'b0});
                end
            end else if (pick < 95) begin
                len = $urandom_range(6, 1);
                for (int j = 0; j < len; j++) begin
                    msg_bytes.push_back({8'($urandom_range(255)), 1'b0});
                end
            end else begin
                msg_bytes.push_back({CH_NUL, 1'b0});
            end
            if (i < n_words - 1 || $urandom_range(2) == 0) begin
                msg_bytes.push_back({pick_delim(), 1'b0});
                if ($urandom_range(3) == 0) begin
                    msg_bytes.push_back({pick_delim(), 1'b0});
                end
            end
        end
        msg_bytes[msg_bytes.size()-1].last = 1'b1;
    endtask

    task automatic drive_message();
        for (int j = 0; j < msg_bytes.size(); j++) begin
            offer_byte(msg_bytes[j].text_byte, msg_bytes[j].last, 1'b0, '0);
        end
    endtask

    // sender pause until every expected score is back, plus pipeline drain
    task automatic wait_idle();
        text_ch.valid = 1'b0;
        while (pending_scores.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_msg_len(input int value);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = MSG_LEN_W'(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // stimulus
    initial begin
        int items;
        int len_value;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.last      = 1'b0;
        row_typed         = 1'b0;
        row_want          = '0;
        src_idle_pct      = 8;
        snk_idle_pct      = 60;
        hold_left         = 0;
        mismatch_count    = 0;
        cycle_count       = 0;

        // message_length stays at its reset value of zero here
        directed_rows = '{
            // two dictionary words
            {8'h74, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h68, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h65, 1'b0, 1'b0, 1'b0, 11'd0},
            {CH_SPACE, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h6f, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h66, 1'b1, 1'b1, 1'b1, 11'd5},
            // zero byte alone: empty message
            {CH_NUL, 1'b1, 1'b1, 1'b0, 11'd0},
            // seven letters: too long to match
            {8'h73, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h70, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h72, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h69, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h6e, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h67, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h73, 1'b1, 1'b1, 1'b0, 11'd0},
            // zero byte ends the string, later bytes ignored
            {8'h73, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h75, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h6e, 1'b0, 1'b0, 1'b0, 11'd0},
            {CH_NUL, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'hff, 1'b1, 1'b1, 1'b1, 11'd3},
            // word in parentheses, last on a delimiter
            {CH_LPAREN, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h6f, 1'b0, 1'b0, 1'b0, 11'd0},
            {8'h66, 1'b0, 1'b0, 1'b0, 11'd0},
            {CH_RPAREN, 1'b1, 1'b0, 1'b0, 11'd0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_byte(directed_rows[i].text_byte, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, idle pattern and message length changing per phase
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph % 3)
                0: begin
                    src_idle_pct = 8;
                    snk_idle_pct = 60;
                end
                1: begin
                    src_idle_pct = 60;
                    snk_idle_pct = 8;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            case (ph)
                0: len_value = SCORE_CEIL;
                1: len_value = 0;
                2: len_value = $urandom_range(24, 1);
                3: len_value = $urandom_range(SCORE_CEIL);
                4: len_value = $urandom_range(12, 1);
                default: len_value = $urandom_range(64);
            endcase
            write_msg_len(len_value);
            items = 0;
            while (items < PHASE_ITEMS) begin
                build_message(6);
                drive_message();
                items += msg_bytes.size();
            end
        end

        // long receiver hold-off while short messages keep coming
        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_msg_len($urandom_range(16));
        hold_left = 300;
        for (int m = 0; m < 20; m++) begin
            build_message(1);
            drive_message();
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("dictionary_word_match_scorer regression: pass");
        end else begin
            $display("dictionary_word_match_scorer regression: fail");
        end
        $finish;
    end

endmodule
